[rtl/yenc_stream_decoder_crc32_defines.svh]
// ----------------------------------------------------------------------------
// yenc stream decoder assertion macros
// Immediate-antecedent and next-cycle property checks, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef YENC_STREAM_DECODER_CRC32_DEFINES_SVH
`define YENC_STREAM_DECODER_CRC32_DEFINES_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define YDEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent must hold in the cycle after the antecedent
`define YDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define YDEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define YDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/ydec_pkg.sv]
// ----------------------------------------------------------------------------
// ydec_pkg
// Shared types, codes and the CRC-32 byte update for the yEnc body decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ydec_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CNT_EXT_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    // commands
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_EOL   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ESCAPE = 2'd1;
    localparam logic [1:0] ST_SIZE   = 2'd2;
    localparam logic [1:0] ST_CRC    = 2'd3;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ESC    = 8'h3D;
    localparam logic [7:0] DATA_OFFSET = 8'd42;
    localparam logic [7:0] ESC_OFFSET  = 8'd64;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [31:0] OUT_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic [31:0] expected_count;
        logic [31:0] expected_crc;
    } t_item;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  decoded_byte;
        logic [1:0]  status;
        logic [31:0] final_crc;
        logic [31:0] decoded_count;
    } t_result;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // byte count clipped to the 32-bit result field
    function automatic logic [31:0] count_out(input logic [COUNT_BITS-1:0] cnt);
        logic [CNT_EXT_W-1:0] e;
        e = CNT_EXT_W'(cnt);
        return (e > CNT_EXT_W'(OUT_MAX)) ? OUT_MAX : e[31:0];
    endfunction

endpackage

[rtl/ydec_in_if.sv]
// ----------------------------------------------------------------------------
// ydec_in_if
// Input channel: command and encoded byte with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ydec_in_if;
    import ydec_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [31:0] expected_count;
    logic [31:0] expected_crc;

    modport source (
        output valid, command, data_byte, expected_count, expected_crc,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, expected_count, expected_crc,
        output ready
    );
endinterface

[rtl/ydec_out_if.sv]
// ----------------------------------------------------------------------------
// ydec_out_if
// Result channel: decoded byte or status with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ydec_out_if;
    import ydec_pkg::*;

    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  decoded_byte;
    logic [1:0]  status;
    logic [31:0] final_crc;
    logic [31:0] decoded_count;

    modport source (
        output valid, byte_valid, decoded_byte, status, final_crc, decoded_count,
        input  ready
    );
    modport sink (
        input  valid, byte_valid, decoded_byte, status, final_crc, decoded_count,
        output ready
    );
endinterface

[rtl/ydec_in_reg.sv]
// ----------------------------------------------------------------------------
// ydec_in_reg
// Input register: captures one beat, frees when the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ydec_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ydec_in_if.sink            i_in,
    input  logic               i_take,
    output logic               o_valid,
    output ydec_pkg::t_item    o_item
);
    import ydec_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command        <= i_in.command;
            r_item.data_byte      <= i_in.data_byte;
            r_item.expected_count <= i_in.expected_count;
            r_item.expected_crc   <= i_in.expected_crc;
        end
    end
endmodule

[rtl/ydec_core.sv]
// ----------------------------------------------------------------------------
// ydec_core
// Decode state, escape handling, crc and count update, result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "yenc_stream_decoder_crc32_defines.svh"

module ydec_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ydec_pkg::t_item    i_item,
    input  logic               i_out_free,
    output logic               o_take,
    output logic               o_load,
    output ydec_pkg::t_result  o_res
);
    import ydec_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DECODING,
        MODE_ERR_ESCAPE,
        MODE_ERR_SIZE
    } t_mode;

    t_mode                 r_mode,  n_mode;
    logic                  r_esc,   n_esc;
    logic [31:0]           r_crc,   n_crc;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic       res_valid;
    logic       byte_out;
    logic [1:0] status;
    logic [7:0] dec_byte;

    always_comb begin
        n_mode    = r_mode;
        n_esc     = r_esc;
        n_crc     = r_crc;
        n_count   = r_count;
        res_valid = 1'b0;
        byte_out  = 1'b0;
        status    = ST_OK;
        dec_byte  = r_esc ? (i_item.data_byte - ESC_OFFSET - DATA_OFFSET)
                          : (i_item.data_byte - DATA_OFFSET);

        if (i_item.command == CMD_START) begin
            n_mode  = MODE_DECODING;
            n_esc   = 1'b0;
            n_crc   = CRC_PRESET;
            n_count = '0;
        end else begin
            case (r_mode)
                MODE_ERR_ESCAPE: begin
                    if (i_item.command == CMD_CHECK) begin
                        res_valid = 1'b1;
                        status    = ST_ESCAPE;
                    end
                end
                MODE_ERR_SIZE: begin
                    if (i_item.command == CMD_CHECK) begin
                        res_valid = 1'b1;
                        status    = ST_SIZE;
                    end
                end
                MODE_DECODING: begin
                    case (i_item.command)
                        CMD_DATA: begin
                            if (!r_esc && i_item.data_byte == CHAR_ESC) begin
                                n_esc = 1'b1;
                            end else if (r_esc || (i_item.data_byte != CHAR_CR
                                                   && i_item.data_byte != CHAR_LF)) begin
                                n_esc     = 1'b0;
                                n_crc     = crc32_byte(r_crc, dec_byte);
                                n_count   = (r_count == '1) ? r_count
                                                            : r_count + COUNT_BITS'(1);
                                res_valid = 1'b1;
                                byte_out  = 1'b1;
                            end
                        end
                        CMD_EOL: begin
                            if (r_esc) begin
                                n_esc     = 1'b0;
                                n_mode    = MODE_ERR_ESCAPE;
                                res_valid = 1'b1;
                                status    = ST_ESCAPE;
                            end
                        end
                        CMD_CHECK: begin
                            res_valid = 1'b1;
                            if (r_esc) begin
                                n_esc  = 1'b0;
                                n_mode = MODE_ERR_ESCAPE;
                                status = ST_ESCAPE;
                            end else if (CNT_EXT_W'(r_count)
                                         != CNT_EXT_W'(i_item.expected_count)) begin
                                n_mode = MODE_ERR_SIZE;
                                status = ST_SIZE;
                            end else begin
                                n_mode = MODE_IDLE;
                                status = (~r_crc != i_item.expected_crc) ? ST_CRC : ST_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // an item with no result never waits on the output register
    assign o_take = i_valid && (!res_valid || i_out_free);
    assign o_load = o_take && res_valid;

    assign o_res.byte_valid    = byte_out;
    assign o_res.decoded_byte  = byte_out ? dec_byte : 8'd0;
    assign o_res.status        = status;
    assign o_res.final_crc     = ~n_crc;
    assign o_res.decoded_count = count_out(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_esc   <= 1'b0;
            r_crc   <= CRC_PRESET;
            r_count <= '0;
        end else if (o_take) begin
            r_mode  <= n_mode;
            r_esc   <= n_esc;
            r_crc   <= n_crc;
            r_count <= n_count;
        end
    end

    `YDEC_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, o_load, i_out_free, "result loaded while output busy")
    `YDEC_ASSERT_NOW(a_esc_only_decoding, i_clk, i_rst_n, r_esc, r_mode == MODE_DECODING, "escape pending outside decoding")
    `YDEC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, o_take && i_item.command == CMD_START, r_mode == MODE_DECODING && r_count == '0 && !r_esc && r_crc == CRC_PRESET, "start did not reset segment state")
endmodule

[rtl/ydec_out_reg.sv]
// ----------------------------------------------------------------------------
// ydec_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "yenc_stream_decoder_crc32_defines.svh"

module ydec_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ydec_pkg::t_result  i_res,
    output logic               o_free,
    ydec_out_if.source         o_out
);
    import ydec_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    assign o_out.valid         = r_valid;
    assign o_out.byte_valid    = r_res.byte_valid;
    assign o_out.decoded_byte  = r_res.decoded_byte;
    assign o_out.status        = r_res.status;
    assign o_out.final_crc     = r_res.final_crc;
    assign o_out.decoded_count = r_res.decoded_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    `YDEC_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load, r_valid, "loaded result not presented")
    `YDEC_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, r_valid && o_out.ready && !i_load, !r_valid, "taken result presented again")
endmodule

[rtl/yenc_stream_decoder_crc32.sv]
// ----------------------------------------------------------------------------
// yenc_stream_decoder_crc32
// yEnc segment body decoder with running CRC-32 and decoded byte count.
// ----------------------------------------------------------------------------
//  port      dir  beat contents
//  i_in      in   command, data_byte, expected_count, expected_crc
//  o_out     out  byte_valid, decoded_byte, status, final_crc, decoded_count
//
//  one beat accepted per cycle while no stalled result holds the core; a result
//  is presented after its beat passes the input register, then the result register
//  the crc byte update and count increment sit between the two registers
//  reset clears mode, escape, count and presets the crc to all ones
//  a stalled result holds the core; beats with no result still pass through
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yenc_stream_decoder_crc32 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ydec_in_if.sink    i_in,
    ydec_out_if.source o_out
);
    import ydec_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    take;
    logic    load;
    logic    out_free;
    t_result res;

    ydec_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    ydec_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (item_valid),
        .i_item     (item),
        .i_out_free (out_free),
        .o_take     (take),
        .o_load     (load),
        .o_res      (res)
    );

    ydec_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );
endmodule
